FILE: rtl/ghci_pkg.sv
// Shared constants, types and hex helpers for the grey hex color inverter.
`default_nettype none

package ghci_pkg;

	localparam int TEXT_W          = 8;
	localparam int MAX_HELD_DIGITS = 7;
	localparam int BURST_MAX       = MAX_HELD_DIGITS + 1;
	localparam int CNT_W           = $clog2(MAX_HELD_DIGITS + 1);
	localparam int LEN_W           = $clog2(BURST_MAX + 1);
	localparam int CFG_IDX_W       = 1;
	localparam int CFG_DATA_W      = 8;

	typedef logic [TEXT_W-1:0] text_t;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_INVERT_ENABLE  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GREY_THRESHOLD = 1'd1;

	localparam logic [7:0] THRESHOLD_RESET = 8'd40;
	localparam logic [CNT_W-1:0] RUN_OVERFLOW = CNT_W'(MAX_HELD_DIGITS);

	// Characters of interest
	localparam text_t CHAR_HASH   = 8'h23;
	localparam text_t CHAR_DQUOTE = 8'h22;
	localparam text_t CHAR_SQUOTE = 8'h27;
	localparam text_t CHAR_COLON  = 8'h3a;
	localparam text_t CHAR_SPACE  = 8'h20;

	// Decode one hex digit of either case: bit 4 set means not a digit
	function automatic logic [4:0] hex_decode(input text_t c);
		logic [4:0] r;
		r = 5'h10;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b0, 4'(c - 8'h30)};
		end else if (c >= 8'h61 && c <= 8'h66) begin
			r = {1'b0, 4'(c - 8'h57)};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r = {1'b0, 4'(c - 8'h37)};
		end
		return r;
	endfunction

	// Encode a nibble as a lowercase hex character
	function automatic text_t hex_char(input logic [3:0] v);
		text_t r;
		if (v < 4'd10) begin
			r = 8'h30 + {4'd0, v};
		end else begin
			r = 8'h57 + {4'd0, v};
		end
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/ghci_ifs.sv
// Stream channel interfaces for the text input and the recolored output.
`default_nettype none

interface ghci_in_if;
	import ghci_pkg::*;
	logic  valid;
	logic  ready;
	text_t text_byte;
	logic  stream_end;
	modport source(output valid, output text_byte, output stream_end, input ready);
	modport sink(input valid, input text_byte, input stream_end, output ready);
endinterface

interface ghci_out_if;
	import ghci_pkg::*;
	logic  valid;
	logic  ready;
	text_t out_byte;
	logic  burst_last;
	logic  out_stream_end;
	modport source(output valid, output out_byte, output burst_last,
		output out_stream_end, input ready);
	modport sink(input valid, input out_byte, input burst_last,
		input out_stream_end, output ready);
endinterface

`default_nettype wire

FILE: rtl/grey_hex_color_inverter.sv
// Top level: filters a text stream and inverts near-grey hex colors.
// A byte passes the input register and then the burst buffer before it can transfer out.
// Throughput: one byte per cycle while out_ch.ready holds; a burst of result bytes drains
// from the burst buffer and holds the input register until its last byte is taken.
// Reset: arst_n clears control state, disables inversion and sets the threshold to 40.
// Held digit storage is not cleared; no clearing pass is needed.
`default_nettype none

module grey_hex_color_inverter (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [ghci_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [ghci_pkg::CFG_DATA_W-1:0] cfg_data,
	ghci_in_if.sink                            in_ch,
	ghci_out_if.source                         out_ch
);
	import ghci_pkg::*;

	// Configuration
	logic       enable_q;
	logic [7:0] thr_q;

	// Input register
	logic  valid_s1;
	text_t byte_s1;
	logic  end_s1;

	// Scan state
	text_t            prev_q;
	logic             open_q;
	logic [CNT_W-1:0] cnt_q;
	text_t            held_q [MAX_HELD_DIGITS];

	// Burst buffer
	logic             bvalid_q;
	logic [LEN_W-1:0] rem_q;
	logic             bend_q;
	text_t            buf_q [BURST_MAX];

	// Combinational results
	logic             out_fire, slot_free, go;
	logic             is_hex, release_run, opening, prev_ok, grey, do_inv, six, three;
	logic [4:0]       dec_in;
	logic [4:0]       dec [MAX_HELD_DIGITS];
	logic [3:0]       nib [MAX_HELD_DIGITS];
	text_t            dig [MAX_HELD_DIGITS];
	text_t            rel [MAX_HELD_DIGITS];
	logic [7:0]       ch [3];
	logic [7:0]       mx, mn;
	logic [CNT_W-1:0] n_eff;
	logic [LEN_W-1:0] len;
	text_t            bb [BURST_MAX];
	logic             open_d;
	logic [CNT_W-1:0] cnt_d;
	text_t            prev_d;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			thr_q    <= THRESHOLD_RESET;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_INVERT_ENABLE:  enable_q <= cfg_data[0];
				CFG_GREY_THRESHOLD: thr_q    <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// Handshake
	assign out_fire    = bvalid_q && out_ch.ready;
	assign slot_free   = !bvalid_q || (out_fire && rem_q == LEN_W'(1));
	assign go          = valid_s1 && slot_free;
	assign in_ch.ready = !valid_s1 || go;

	// Build the burst for the item in the input register
	always_comb begin
		dec_in = hex_decode(byte_s1);
		is_hex = !dec_in[4];
		for (int k = 0; k < MAX_HELD_DIGITS; k++) begin
			dig[k] = (is_hex && cnt_q == CNT_W'(k)) ? byte_s1 : held_q[k];
			dec[k] = hex_decode(dig[k]);
			nib[k] = dec[k][3:0];
		end
		n_eff = is_hex ? cnt_q + CNT_W'(1) : cnt_q;
		six   = (n_eff == CNT_W'(6));
		three = (n_eff == CNT_W'(3));
		for (int k = 0; k < 3; k++) begin
			ch[k] = six ? {nib[2*k], nib[2*k+1]} : {nib[k], nib[k]};
		end
		// spread of the three channels
		mx = ch[0];
		mn = ch[0];
		for (int k = 1; k < 3; k++) begin
			if (ch[k] > mx) mx = ch[k];
			if (ch[k] < mn) mn = ch[k];
		end
		grey   = (mx - mn) <= thr_q;
		do_inv = enable_q && (six || three) && grey;
		// inverted digit is 15 minus the digit in both color lengths
		for (int k = 0; k < MAX_HELD_DIGITS; k++) begin
			rel[k] = do_inv ? hex_char(~nib[k]) : dig[k];
		end
		prev_ok = (prev_q == CHAR_DQUOTE) || (prev_q == CHAR_SQUOTE) ||
			(prev_q == CHAR_COLON) || (prev_q == CHAR_SPACE);
		opening = !open_q && byte_s1 == CHAR_HASH && enable_q && !end_s1 && prev_ok;
		release_run = open_q && (!is_hex || n_eff == RUN_OVERFLOW || end_s1);

		for (int k = 0; k < BURST_MAX; k++) begin
			bb[k] = byte_s1;
		end
		len    = '0;
		open_d = open_q;
		cnt_d  = cnt_q;
		if (release_run) begin
			bb[0] = CHAR_HASH;
			for (int k = 1; k < BURST_MAX; k++) begin
				if (LEN_W'(k - 1) < LEN_W'(n_eff)) bb[k] = rel[k-1];
			end
			len    = LEN_W'(n_eff) + LEN_W'(1) + LEN_W'(!is_hex);
			open_d = 1'b0;
			cnt_d  = '0;
		end else if (open_q) begin
			cnt_d = n_eff;
		end else if (opening) begin
			open_d = 1'b1;
			cnt_d  = '0;
		end else begin
			len = LEN_W'(1);
		end
		prev_d = byte_s1;
		if (end_s1) begin
			prev_d = '0;
			open_d = 1'b0;
			cnt_d  = '0;
		end
	end

	// Advance the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			byte_s1 <= in_ch.text_byte;
			end_s1  <= in_ch.stream_end;
		end
	end

	// Update scan state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
			open_q <= 1'b0;
			cnt_q  <= '0;
		end else if (go) begin
			prev_q <= prev_d;
			open_q <= open_d;
			cnt_q  <= cnt_d;
		end
	end

	// Hold incoming digits
	always_ff @(posedge clk) begin
		if (go && open_q && is_hex && cnt_q < RUN_OVERFLOW) begin
			held_q[cnt_q[CNT_W-1:0]] <= byte_s1;
		end
	end

	// Load or drain the burst buffer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bvalid_q <= 1'b0;
			rem_q    <= '0;
			bend_q   <= 1'b0;
		end else if (go && len != '0) begin
			bvalid_q <= 1'b1;
			rem_q    <= len;
			bend_q   <= end_s1;
		end else if (out_fire) begin
			rem_q <= rem_q - LEN_W'(1);
			if (rem_q == LEN_W'(1)) bvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go && len != '0) begin
			for (int k = 0; k < BURST_MAX; k++) buf_q[k] <= bb[k];
		end else if (out_fire) begin
			for (int k = 0; k < BURST_MAX - 1; k++) buf_q[k] <= buf_q[k+1];
		end
	end

	// Drive the output channel
	assign out_ch.valid          = bvalid_q;
	assign out_ch.out_byte       = buf_q[0];
	assign out_ch.burst_last     = (rem_q == LEN_W'(1));
	assign out_ch.out_stream_end = (rem_q == LEN_W'(1)) && bend_q;

	// Checks
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		bvalid_q |-> (rem_q != '0 && rem_q <= LEN_W'(BURST_MAX)))
		else $error("burst count out of range");
	a_closed_count: assert property (@(posedge clk) disable iff (!arst_n)
		!open_q |-> cnt_q == '0)
		else $error("digit count nonzero with no open color");
	a_open_count: assert property (@(posedge clk) disable iff (!arst_n)
		open_q |-> cnt_q < RUN_OVERFLOW)
		else $error("open color holds an overflowing run");
	a_end_flush: assert property (@(posedge clk) disable iff (!arst_n)
		(go && end_s1) |=> (!open_q && prev_q == '0))
		else $error("stream end left scan state behind");
	a_end_has_output: assert property (@(posedge clk) disable iff (!arst_n)
		(go && end_s1) |-> len != '0)
		else $error("stream end produced no output");

endmodule

`default_nettype wire
